### hdl/plucked_string_voice_top_macros.svh
// Assertion macros shared by the plucked string voice RTL.
`ifndef PLUCKED_STRING_VOICE_TOP_MACROS_SVH
`define PLUCKED_STRING_VOICE_TOP_MACROS_SVH

// Implication or plain property, checked on every clock edge outside reset.
`define PSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Invariant that must hold on every clock edge outside reset.
`define PSV_CHECK_INV(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### hdl/psv_pkg.sv
// Shared constants, types and controller/datapath interface structs of the voice.
package psv_pkg;

  localparam int MAX_PERIOD   = 4096;
  localparam int TAIL_SAMPLES = 1024;
  localparam int POS_W        = $clog2(MAX_PERIOD);
  localparam int PER_W        = POS_W + 1;
  localparam int LEN_W        = 24;
  localparam int CNT_W        = LEN_W + 1;
  localparam int SMP_W        = 16;
  localparam int QUO_W        = SMP_W;
  localparam int DVD_W        = QUO_W + LEN_W;
  localparam int STEP_W       = $clog2(QUO_W);
  localparam int DATA_W       = 32;
  localparam int REG_CNT      = 4;
  localparam int ADDR_W       = $clog2(REG_CNT) + 2;

  localparam logic [PER_W-1:0] PERIOD_RESET  = PER_W'(100);
  localparam logic [LEN_W-1:0] ATTACK_RESET  = LEN_W'(0);
  localparam logic [LEN_W-1:0] REL_RESET     = LEN_W'(1);
  localparam logic [LEN_W-1:0] DUR_RESET     = LEN_W'(0);

  typedef enum logic [$clog2(REG_CNT)-1:0] {
    REG_PERIOD,
    REG_ATTACK,
    REG_RELEASE,
    REG_DURATION
  } reg_idx_t;

  typedef enum logic [1:0] {
    ENV_PASS,
    ENV_ZERO,
    ENV_SCALE
  } env_mode_t;

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [LEN_W-1:0] attack;
    logic [LEN_W-1:0] rel_len;
    logic [LEN_W-1:0] duration;
  } cfg_t;

  typedef struct packed {
    logic accept;         // input transaction taken this cycle
    logic env;            // delay line read data is valid: filter and envelope select
    logic mul;            // register the envelope product
    logic div_env_start;  // start the divider on the envelope product
    logic div_pos_start;  // start the divider on a position wrap
    logic fin;            // load the output register and advance the counters
    logic pos_take;       // take the divider remainder as the new position
    logic pos_is_read;    // position under work: 1 read, 0 load
  } psv_cmd_t;

  typedef struct packed {
    logic lp_simple;  // load position advances without a division
    logic rp_simple;  // read position advances without a division
    logic scale;      // envelope needs a division
    logic last;       // current tick ends the note
    logic out_free;   // output register can take a result this cycle
    logic div_busy;
  } psv_stat_t;

endpackage

### hdl/psv_div.sv
// Restoring divider, one quotient bit per cycle, for dividends whose quotient fits QUO_W bits.
`include "plucked_string_voice_top_macros.svh"

module psv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [psv_pkg::DVD_W-1:0]  dividend,
  input  logic [psv_pkg::LEN_W-1:0]  divisor,
  output logic                       busy,
  output logic [psv_pkg::QUO_W-1:0]  quotient,
  output logic [psv_pkg::LEN_W-1:0]  remainder
);
  import psv_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  sh_r, sh_nxt;
  logic [LEN_W-1:0]  den_r, den_nxt;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diff;
  logic              ge;

  // The caller guarantees dividend / 2**QUO_W < divisor, so the top part
  // already is a valid partial remainder.
  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = dividend[DVD_W-1:QUO_W];
      sh_nxt   = dividend[QUO_W-1:0];
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      sh_nxt   = {sh_r[QUO_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = sh_r;
  assign remainder = rem_r;

  `PSV_ASSERT(a_div_no_restart, start |-> !busy_r, "divider started while busy")
  `PSV_CHECK_INV(a_div_rem_lt, !busy_r || (rem_r < den_r), "partial remainder not below divisor")

endmodule

### hdl/psv_dp.sv
// Voice datapath: delay line, filter, envelope multiply and divide, counters, output register.
module psv_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psv_pkg::cfg_t                     cfg,
  input  psv_pkg::psv_cmd_t                 cmd,
  output psv_pkg::psv_stat_t                stat,
  input  logic                              in_action,
  input  logic signed [psv_pkg::SMP_W-1:0]  in_noise_value,
  input  logic signed [psv_pkg::SMP_W-1:0]  in_mix_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [psv_pkg::SMP_W-1:0]  out_sample_out,
  output logic                              out_note_last
);
  import psv_pkg::*;

  function automatic logic signed [SMP_W-1:0] half_trunc(input logic signed [SMP_W-1:0] x);
    logic signed [SMP_W-1:0] t;
    t = x + SMP_W'(x[SMP_W-1]);
    return t >>> 1;
  endfunction

  logic [SMP_W-1:0] mem [MAX_PERIOD];
  logic [SMP_W-1:0] rdata_r;
  logic             mem_we;
  logic [POS_W-1:0] mem_waddr;
  logic [SMP_W-1:0] mem_wdata;

  logic signed [SMP_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0]        rp_r, rp_nxt;
  logic [POS_W-1:0]        lp_r, lp_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic signed [SMP_W-1:0] mix_r;
  logic signed [SMP_W-1:0] d_r;
  env_mode_t               mode_r, mode_c;
  logic [LEN_W-1:0]        num_r, num_c;
  logic [LEN_W-1:0]        den_r, den_c;
  logic [DVD_W-1:0]        prod_r;
  logic signed [SMP_W-1:0] out_sample_r;
  logic                    out_last_r;

  logic [PER_W-1:0]        per_eff;
  logic [PER_W-1:0]        lp_inc, rp_inc;
  logic [POS_W-1:0]        lp_adv, rp_adv;
  logic signed [SMP_W-1:0] d_c;
  logic [SMP_W-1:0]        d_mag;
  logic [DVD_W-1:0]        prod_c;
  logic [SMP_W-1:0]        voice_c;
  logic [SMP_W-1:0]        sum_c;
  logic [CNT_W:0]          total_c;
  logic                    last_c;
  logic [CNT_W:0]          rel_end;

  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd;
  logic [LEN_W-1:0]        div_dvs;
  logic                    div_busy;
  logic [QUO_W-1:0]        div_quo;
  logic [LEN_W-1:0]        div_rem;

  // Period in use, clamped to the legal range.
  always_comb begin
    priority if (cfg.period < PER_W'(2)) begin
      per_eff = PER_W'(2);
    end else if (cfg.period > PER_W'(MAX_PERIOD)) begin
      per_eff = PER_W'(MAX_PERIOD);
    end else begin
      per_eff = cfg.period;
    end
  end

  // A position one short of the period wraps to zero; one at or past it
  // (after the period shrank) needs a true modulo from the divider.
  assign lp_inc = {1'b0, lp_r} + PER_W'(1);
  assign rp_inc = {1'b0, rp_r} + PER_W'(1);
  assign lp_adv = (lp_inc == per_eff) ? '0 : lp_inc[POS_W-1:0];
  assign rp_adv = (rp_inc == per_eff) ? '0 : rp_inc[POS_W-1:0];

  // Delay line: one write port, one registered read port at the read position.
  assign mem_we    = (cmd.accept && !in_action) || cmd.env;
  assign mem_waddr = cmd.env ? rp_r : lp_r;
  assign mem_wdata = cmd.env ? d_c : in_noise_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rp_r];
  end

  assign d_c = half_trunc($signed(rdata_r)) + half_trunc(prev_r);

  // Envelope select on the sample count.
  assign rel_end = {1'b0, cnt_r} + (CNT_W + 1)'(cfg.rel_len);

  always_comb begin
    mode_c = ENV_PASS;
    num_c  = '0;
    den_c  = cfg.rel_len;
    priority if (cnt_r < {1'b0, cfg.attack}) begin
      mode_c = ENV_SCALE;
      num_c  = cnt_r[LEN_W-1:0];
      den_c  = cfg.attack;
    end else if (rel_end > (CNT_W + 1)'(cfg.duration)) begin
      if ((cnt_r >= {1'b0, cfg.duration}) || (cfg.rel_len == '0)) begin
        mode_c = ENV_ZERO;
      end else begin
        mode_c = ENV_SCALE;
        num_c  = cfg.duration - cnt_r[LEN_W-1:0];
      end
    end else begin
      mode_c = ENV_PASS;
    end
  end

  assign d_mag  = d_r[SMP_W-1] ? (~d_r + 1'b1) : d_r;
  assign prod_c = d_mag * num_r;

  always_comb begin
    unique case (mode_r)
      ENV_PASS:  voice_c = d_r;
      ENV_ZERO:  voice_c = '0;
      ENV_SCALE: voice_c = d_r[SMP_W-1] ? (~div_quo + 1'b1) : div_quo;
      default:   voice_c = '0;
    endcase
  end

  assign sum_c   = mix_r + voice_c;
  assign total_c = (CNT_W + 1)'(cfg.duration) + (CNT_W + 1)'(TAIL_SAMPLES);
  assign last_c  = (({1'b0, cnt_r} + (CNT_W + 1)'(1)) >= total_c);

  assign div_start = cmd.div_env_start || cmd.div_pos_start;
  assign div_dvd   = cmd.div_env_start ? prod_r
                   : DVD_W'(cmd.pos_is_read ? rp_inc : lp_inc);
  assign div_dvs   = cmd.div_env_start ? den_r : LEN_W'(per_eff);

  psv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    prev_nxt      = prev_r;
    rp_nxt        = rp_r;
    lp_nxt        = lp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.accept && !in_action && stat.lp_simple) begin
      lp_nxt = lp_adv;
    end
    if (cmd.env) begin
      prev_nxt = d_c;
    end
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
      if (last_c) begin
        cnt_nxt  = '0;
        rp_nxt   = '0;
        lp_nxt   = '0;
        prev_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (stat.rp_simple) begin
          rp_nxt = rp_adv;
        end
      end
    end
    if (cmd.pos_take) begin
      if (cmd.pos_is_read) begin
        rp_nxt = div_rem[POS_W-1:0];
      end else begin
        lp_nxt = div_rem[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      rp_r        <= '0;
      lp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      rp_r        <= rp_nxt;
      lp_r        <= lp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mix_r <= in_mix_in;
    end
    if (cmd.env) begin
      d_r    <= d_c;
      mode_r <= mode_c;
      num_r  <= num_c;
      den_r  <= den_c;
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.fin) begin
      out_sample_r <= sum_c;
      out_last_r   <= last_c;
    end
  end

  assign stat.lp_simple = (lp_inc <= per_eff);
  assign stat.rp_simple = (rp_inc <= per_eff);
  assign stat.scale     = (mode_r == ENV_SCALE);
  assign stat.last      = last_c;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.div_busy  = div_busy;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_note_last  = out_last_r;

endmodule

### hdl/psv_ctrl.sv
// Voice controller: sequences load and tick transactions through the datapath.
`include "plucked_string_voice_top_macros.svh"

module psv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  psv_pkg::psv_stat_t  stat,
  output psv_pkg::psv_cmd_t   cmd
);
  import psv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_MUL,
    S_DST,
    S_DIV,
    S_FIN,
    S_ADV
  } state_t;

  state_t state_r, state_nxt;
  logic   adv_rp_r, adv_rp_nxt;

  always_comb begin
    state_nxt  = state_r;
    adv_rp_nxt = adv_rp_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action) begin
            state_nxt = S_ENV;
          end else if (!stat.lp_simple) begin
            cmd.div_pos_start = 1'b1;
            adv_rp_nxt        = 1'b0;
            state_nxt         = S_ADV;
          end
        end
      end
      S_ENV: begin
        cmd.env   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.scale ? S_DST : S_FIN;
      end
      S_DST: begin
        cmd.div_env_start = 1'b1;
        state_nxt         = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.pos_is_read = 1'b1;
        if (stat.out_free) begin
          cmd.fin = 1'b1;
          if (!stat.last && !stat.rp_simple) begin
            cmd.div_pos_start = 1'b1;
            adv_rp_nxt        = 1'b1;
            state_nxt         = S_ADV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADV: begin
        cmd.pos_is_read = adv_rp_r;
        if (!stat.div_busy) begin
          cmd.pos_take = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      adv_rp_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      adv_rp_r <= adv_rp_nxt;
    end
  end

  `PSV_ASSERT(a_ctrl_div_owned, stat.div_busy |-> (state_r == S_DIV || state_r == S_ADV), "divider busy outside a wait state")
  `PSV_ASSERT(a_ctrl_fin_div_idle, cmd.fin |-> !stat.div_busy, "result written while divider still running")

endmodule

### hdl/psv_regs.sv
// APB-style configuration registers of the voice.
module psv_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psv_pkg::ADDR_W-1:0]   paddr,
  input  logic [psv_pkg::DATA_W-1:0]   pwdata,
  output logic [psv_pkg::DATA_W-1:0]   prdata,
  output psv_pkg::cfg_t                cfg
);
  import psv_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PERIOD:   cfg_nxt.period   = pwdata[PER_W-1:0];
        REG_ATTACK:   cfg_nxt.attack   = pwdata[LEN_W-1:0];
        REG_RELEASE:  cfg_nxt.rel_len  = pwdata[LEN_W-1:0];
        REG_DURATION: cfg_nxt.duration = pwdata[LEN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD:   prdata = DATA_W'(cfg_r.period);
      REG_ATTACK:   prdata = DATA_W'(cfg_r.attack);
      REG_RELEASE:  prdata = DATA_W'(cfg_r.rel_len);
      REG_DURATION: prdata = DATA_W'(cfg_r.duration);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period   <= PERIOD_RESET;
      cfg_r.attack   <= ATTACK_RESET;
      cfg_r.rel_len  <= REL_RESET;
      cfg_r.duration <= DUR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/plucked_string_voice_top.sv
// Top level of the plucked string voice: registers, controller and datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_ready  | in_action, in_noise_value, in_mix_in
//  output   | out_valid/out_ready| out_sample_out, out_note_last
//  config   | psel/penable/pready| pwrite, paddr, pwdata, prdata
//
// A load transaction ends in S_IDLE, or passes S_ADV for a modulo when its
// position is past a shrunk period. A tick on a flat or silent envelope runs
// S_ENV, S_MUL and S_FIN; an attack or release ramp adds S_DST and S_DIV for
// the 16-step divider, and a read position past a shrunk period adds S_ADV.
// Reset is synchronous; the delay line is not cleared and holds garbage
// until loaded. A finished sample waits in the output register while the
// next transaction is taken; the controller stalls only when a second
// result is ready and the first has not been taken.
module plucked_string_voice_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic signed [psv_pkg::SMP_W-1:0]  in_noise_value,
  input  logic signed [psv_pkg::SMP_W-1:0]  in_mix_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [psv_pkg::SMP_W-1:0]  out_sample_out,
  output logic                              out_note_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psv_pkg::ADDR_W-1:0]        paddr,
  input  logic [psv_pkg::DATA_W-1:0]        pwdata,
  output logic [psv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import psv_pkg::*;

  cfg_t      cfg;
  psv_cmd_t  cmd;
  psv_stat_t stat;

  assign pready = 1'b1;

  psv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  psv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psv_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_noise_value (in_noise_value),
    .in_mix_in      (in_mix_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_note_last  (out_note_last)
  );

endmodule
